### sv/aoqt_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and codes of the box overlap table
package aoqt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int MAX_OUT = 32;
  localparam int RES_W   = $clog2(MAX_OUT + 1);
  localparam int TAG_W   = 16;
  localparam int CRD_W   = 32;
  localparam int OIDX_W  = 5;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD       = 2'd1,
    OP_QUERY_TAG = 2'd2,
    OP_QUERY_BOX = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_MATCH      = 3'd0,
    ST_NO_MATCH   = 3'd1,
    ST_NOT_IN_MAP = 3'd2,
    ST_ADDED      = 3'd3,
    ST_FULL       = 3'd4,
    ST_CLEARED    = 3'd5
  } status_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] min_x;
    logic signed [CRD_W-1:0] min_y;
    logic signed [CRD_W-1:0] min_z;
    logic signed [CRD_W-1:0] max_x;
    logic signed [CRD_W-1:0] max_y;
    logic signed [CRD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    box_t             box;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } mem_req_t;

  function automatic logic [OIDX_W-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [IDX_W+OIDX_W-1:0] ext;
    ext = {{OIDX_W{1'b0}}, i};
    return ext[OIDX_W-1:0];
  endfunction

endpackage

### sv/aoqt_sat.sv
`timescale 1ns / 1ps
// saturating origin plus offset adders that form the box of an item
module aoqt_sat
  import aoqt_pkg::*;
(
  input  logic signed [aoqt_pkg::CRD_W-1:0] origin_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] origin_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] origin_z_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] lo_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] lo_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] lo_z_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] hi_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] hi_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0] hi_z_i,
  output aoqt_pkg::box_t                    box_o
);

  function automatic logic signed [CRD_W-1:0] sat_add(input logic signed [CRD_W-1:0] a,
                                                      input logic signed [CRD_W-1:0] b);
    logic [CRD_W:0] s;
    s = {a[CRD_W-1], a} + {b[CRD_W-1], b};
    if (s[CRD_W] != s[CRD_W-1]) begin
      return s[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
    end
    return s[CRD_W-1:0];
  endfunction

  always_comb begin
    box_o.min_x = sat_add(origin_x_i, lo_x_i);
    box_o.min_y = sat_add(origin_y_i, lo_y_i);
    box_o.min_z = sat_add(origin_z_i, lo_z_i);
    box_o.max_x = sat_add(origin_x_i, hi_x_i);
    box_o.max_y = sat_add(origin_y_i, hi_y_i);
    box_o.max_z = sat_add(origin_z_i, hi_z_i);
  end

endmodule

### sv/aoqt_store.sv
`timescale 1ns / 1ps
// entry memory: one write port, one registered read port
module aoqt_store
  import aoqt_pkg::*;
(
  input  logic               clk_i,
  input  aoqt_pkg::mem_req_t req_i,
  output aoqt_pkg::entry_t   rd_data_o
);

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/aoqt_ctrl.sv
`timescale 1ns / 1ps
// sequencer: add, clear, tag lookup and overlap scan over the entry memory
module aoqt_ctrl
  import aoqt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [aoqt_pkg::TAG_W-1:0]    object_tag_i,
  input  aoqt_pkg::box_t                box_i,
  output aoqt_pkg::mem_req_t            mem_req_o,
  input  aoqt_pkg::entry_t              rd_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [aoqt_pkg::OIDX_W-1:0]   match_index_o,
  output logic [aoqt_pkg::TAG_W-1:0]    match_tag_o,
  output logic                          last_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  box_t              qbox_q, qbox_d;
  logic [TAG_W-1:0]  qtag_q, qtag_d;
  logic              skip_vld_q, skip_vld_d;
  logic [IDX_W-1:0]  skip_idx_q, skip_idx_d;
  logic [RES_W-1:0]  hits_q, hits_d;
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic [TAG_W-1:0]  pend_tag_q, pend_tag_d;
  logic              out_vld_q, out_vld_d;
  status_e           out_status_q, out_status_d;
  logic [OIDX_W-1:0] out_idx_q, out_idx_d;
  logic [TAG_W-1:0]  out_tag_q, out_tag_d;
  logic              out_last_q, out_last_d;

  logic in_acc, out_free, more, ovl, skip, hit, tag_hit, scan_hold;
  op_e  op;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != S_IDLE) || out_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign more       = (issue_q != count_q);

  assign ovl = ($signed(qbox_q.min_x) <= $signed(rd_data_i.box.max_x)) &&
               ($signed(rd_data_i.box.min_x) <= $signed(qbox_q.max_x)) &&
               ($signed(qbox_q.min_y) <= $signed(rd_data_i.box.max_y)) &&
               ($signed(rd_data_i.box.min_y) <= $signed(qbox_q.max_y)) &&
               ($signed(qbox_q.min_z) <= $signed(rd_data_i.box.max_z)) &&
               ($signed(rd_data_i.box.min_z) <= $signed(qbox_q.max_z));
  assign skip      = skip_vld_q && (rd_idx_q == skip_idx_q);
  assign hit       = rd_vld_q && ovl && !skip && (hits_q != RES_W'(MAX_OUT));
  assign tag_hit   = rd_vld_q && (rd_data_i.tag == qtag_q);
  assign scan_hold = hit && pend_vld_q && !out_free;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    rd_vld_d     = rd_vld_q;
    rd_idx_d     = rd_idx_q;
    qbox_d       = qbox_q;
    qtag_d       = qtag_q;
    skip_vld_d   = skip_vld_q;
    skip_idx_d   = skip_idx_q;
    hits_d       = hits_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    pend_tag_d   = pend_tag_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;
    mem_req_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_idx_d  = '0;
          out_tag_d  = '0;
          out_last_d = 1'b1;
          issue_d    = '0;
          rd_vld_d   = 1'b0;
          hits_d     = '0;
          pend_vld_d = 1'b0;
          unique case (op)
            OP_CLEAR: begin
              count_d      = '0;
              out_vld_d    = 1'b1;
              out_status_d = ST_CLEARED;
            end
            OP_ADD: begin
              out_vld_d = 1'b1;
              if (count_q == CNT_W'(ENTRIES)) begin
                out_status_d = ST_FULL;
              end else begin
                mem_req_o.wr_en       = 1'b1;
                mem_req_o.wr_idx      = count_q[IDX_W-1:0];
                mem_req_o.wr_data.tag = object_tag_i;
                mem_req_o.wr_data.box = box_i;
                count_d               = count_q + CNT_W'(1);
                out_status_d          = ST_ADDED;
              end
            end
            OP_QUERY_TAG: begin
              qtag_d = object_tag_i;
              if (count_q == '0) begin
                out_vld_d    = 1'b1;
                out_status_d = ST_NOT_IN_MAP;
              end else begin
                state_d = S_LOOKUP;
              end
            end
            OP_QUERY_BOX: begin
              qbox_d     = box_i;
              skip_vld_d = 1'b0;
              state_d    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        if (tag_hit) begin
          qbox_d     = rd_data_i.box;
          skip_vld_d = 1'b1;
          skip_idx_d = rd_idx_q;
          issue_d    = '0;
          rd_vld_d   = 1'b0;
          state_d    = S_SCAN;
        end else if (more) begin
          mem_req_o.rd_en  = 1'b1;
          mem_req_o.rd_idx = issue_q[IDX_W-1:0];
          rd_vld_d         = 1'b1;
          rd_idx_d         = issue_q[IDX_W-1:0];
          issue_d          = issue_q + CNT_W'(1);
        end else begin
          rd_vld_d     = 1'b0;
          out_vld_d    = 1'b1;
          out_status_d = ST_NOT_IN_MAP;
          out_idx_d    = '0;
          out_tag_d    = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!scan_hold) begin
          if (hit) begin
            hits_d = hits_q + RES_W'(1);
            if (pend_vld_q) begin
              out_vld_d    = 1'b1;
              out_status_d = ST_MATCH;
              out_idx_d    = idx_out(pend_idx_q);
              out_tag_d    = pend_tag_q;
              out_last_d   = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = rd_idx_q;
            pend_tag_d = rd_data_i.tag;
          end
          if (more) begin
            mem_req_o.rd_en  = 1'b1;
            mem_req_o.rd_idx = issue_q[IDX_W-1:0];
            rd_vld_d         = 1'b1;
            rd_idx_d         = issue_q[IDX_W-1:0];
            issue_d          = issue_q + CNT_W'(1);
          end else begin
            rd_vld_d = 1'b0;
            if (!rd_vld_q) begin
              state_d = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          if (pend_vld_q) begin
            out_status_d = ST_MATCH;
            out_idx_d    = idx_out(pend_idx_q);
            out_tag_d    = pend_tag_q;
          end else begin
            out_status_d = ST_NO_MATCH;
            out_idx_d    = '0;
            out_tag_d    = '0;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      skip_vld_q <= 1'b0;
      hits_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      issue_q    <= issue_d;
      rd_vld_q   <= rd_vld_d;
      skip_vld_q <= skip_vld_d;
      hits_q     <= hits_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    qbox_q       <= qbox_d;
    qtag_q       <= qtag_d;
    skip_idx_q   <= skip_idx_d;
    pend_idx_q   <= pend_idx_d;
    pend_tag_q   <= pend_tag_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign match_index_o = out_idx_q;
  assign match_tag_o   = out_tag_q;
  assign last_o        = out_last_q;

endmodule

### sv/aabb_overlap_query_table.sv
`timescale 1ns / 1ps
// clear and add: result in the cycle after the transfer, next item taken once it has gone
// box query: one entry per cycle from the single read port, unless an output stall holds the scan
// tag query: lookup pass to the first matching slot, then the box scan
// one item at a time; an output stall holds the scan only when a second match is ready
// reset clears the entry count and control state; the entry memory itself is not cleared
module aabb_overlap_query_table
  import aoqt_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [aoqt_pkg::TAG_W-1:0]         object_tag_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  origin_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  origin_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  origin_z_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  lo_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  lo_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  lo_z_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  hi_x_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  hi_y_i,
  input  logic signed [aoqt_pkg::CRD_W-1:0]  hi_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [aoqt_pkg::OIDX_W-1:0]        match_index_o,
  output logic [aoqt_pkg::TAG_W-1:0]         match_tag_o,
  output logic                               last_o
);

  box_t     in_box;
  mem_req_t mem_req;
  entry_t   rd_data;

  aoqt_sat u_sat (
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .lo_x_i     (lo_x_i),
    .lo_y_i     (lo_y_i),
    .lo_z_i     (lo_z_i),
    .hi_x_i     (hi_x_i),
    .hi_y_i     (hi_y_i),
    .hi_z_i     (hi_z_i),
    .box_o      (in_box)
  );

  aoqt_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  aoqt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .object_tag_i  (object_tag_i),
    .box_i         (in_box),
    .mem_req_o     (mem_req),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .match_index_o (match_index_o),
    .match_tag_o   (match_tag_o),
    .last_o        (last_o)
  );

endmodule

### sv/aoqt_chk.sv
`timescale 1ns / 1ps
// port checker for the box overlap table and its bind
module aoqt_chk
  import aoqt_pkg::*;
(
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [1:0]                         operation_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [2:0]                         status_o,
  input logic [aoqt_pkg::OIDX_W-1:0]        match_index_o,
  input logic [aoqt_pkg::TAG_W-1:0]         match_tag_o,
  input logic                               last_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_MATCH) |->
      last_o && (match_index_o == '0) && (match_tag_o == '0))
    else $error("non-match result not a lone final result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("second item taken before first finished");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (operation_i == OP_CLEAR) |=>
      out_valid_o && (status_o == ST_CLEARED) && last_o)
    else $error("clear not answered in the next cycle");

  a_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (operation_i == OP_ADD) |=>
      out_valid_o && ((status_o == ST_ADDED) || (status_o == ST_FULL)))
    else $error("add not answered in the next cycle");

endmodule

bind aabb_overlap_query_table aoqt_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .match_index_o (match_index_o),
  .match_tag_o   (match_tag_o),
  .last_o        (last_o)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// testbench of the box overlap table: directed rows, then random add and query rounds
module tb_top;
  import aoqt_pkg::*;

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam crd_t C_MAX     = 32'sh7fff_ffff;
  localparam crd_t C_MIN     = 32'sh8000_0000;
  localparam crd_t C_ONE     = 32'sh0001_0000;
  localparam int   N_ITEMS   = 500;
  localparam int   CALM_AT   = 440;
  localparam int   LONG_HOLD = 150;
  localparam int   TAIL      = 80;

  typedef struct {
    op_e              op;
    logic [TAG_W-1:0] tag;
    crd_t             ox, oy, oz, lx, ly, lz, hx, hy, hz;
    bit               pinned;
    status_e          want;
  } req_t;

  typedef struct {
    status_e           st;
    logic [OIDX_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [OIDX_W-1:0] out_index;
  logic [TAG_W-1:0]  out_tag;
  logic              out_last;
  req_t              cur;

  int               n_boxes;
  logic [TAG_W-1:0] slot_tag [ENTRIES];
  box_t             slot_box [ENTRIES];
  res_t             pending_results [$];
  int               n_bad;
  int               n_sent;
  bit               no_idle;
  bit               hold_req;

  aabb_overlap_query_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (cur.op),
    .object_tag_i  (cur.tag),
    .origin_x_i    (cur.ox),
    .origin_y_i    (cur.oy),
    .origin_z_i    (cur.oz),
    .lo_x_i        (cur.lx),
    .lo_y_i        (cur.ly),
    .lo_z_i        (cur.lz),
    .hi_x_i        (cur.hx),
    .hi_y_i        (cur.hy),
    .hi_z_i        (cur.hz),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (out_status),
    .match_index_o (out_index),
    .match_tag_o   (out_tag),
    .last_o        (out_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic crd_t clamp_sum(crd_t a, crd_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(C_MAX)) return C_MAX;
    if (s < longint'(C_MIN)) return C_MIN;
    return s[CRD_W-1:0];
  endfunction

  function automatic bit boxes_meet(box_t a, box_t b);
    return a.min_x <= b.max_x && b.min_x <= a.max_x &&
           a.min_y <= b.max_y && b.min_y <= a.max_y &&
           a.min_z <= b.max_z && b.min_z <= a.max_z;
  endfunction

  function automatic void add_result(status_e st, int idx, logic [TAG_W-1:0] tag, logic last);
    res_t r;
    r.st   = st;
    r.idx  = idx[OIDX_W-1:0];
    r.tag  = tag;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void scan_slots(box_t q, bit skip, int self);
    int   n;
    res_t r;
    n = 0;
    for (int i = 0; i < n_boxes; i++) begin
      if (skip && i == self) continue;
      if (n >= MAX_OUT) break;
      if (boxes_meet(q, slot_box[i])) begin
        add_result(ST_MATCH, i, slot_tag[i], 1'b0);
        n++;
      end
    end
    if (n == 0) begin
      add_result(ST_NO_MATCH, 0, '0, 1'b1);
    end else begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void compute_overlaps(req_t r);
    box_t q;
    int   self;
    q.min_x = clamp_sum(r.ox, r.lx);
    q.min_y = clamp_sum(r.oy, r.ly);
    q.min_z = clamp_sum(r.oz, r.lz);
    q.max_x = clamp_sum(r.ox, r.hx);
    q.max_y = clamp_sum(r.oy, r.hy);
    q.max_z = clamp_sum(r.oz, r.hz);
    case (r.op)
      OP_CLEAR: begin
        n_boxes = 0;
        add_result(ST_CLEARED, 0, '0, 1'b1);
      end
      OP_ADD: begin
        if (n_boxes >= ENTRIES) begin
          add_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          slot_tag[n_boxes] = r.tag;
          slot_box[n_boxes] = q;
          n_boxes++;
          add_result(ST_ADDED, 0, '0, 1'b1);
        end
      end
      OP_QUERY_TAG: begin
        self = -1;
        for (int i = 0; i < n_boxes; i++) begin
          if (slot_tag[i] == r.tag) begin
            self = i;
            break;
          end
        end
        if (self < 0) add_result(ST_NOT_IN_MAP, 0, '0, 1'b1);
        else scan_slots(slot_box[self], 1'b1, self);
      end
      default: scan_slots(q, 1'b0, 0);
    endcase
  endfunction

  function automatic req_t mk(op_e op, logic [TAG_W-1:0] tag, crd_t o, crd_t l, crd_t h);
    req_t r;
    r.op = op;
    r.tag = tag;
    {r.ox, r.oy, r.oz} = {3{o}};
    {r.lx, r.ly, r.lz} = {3{l}};
    {r.hx, r.hy, r.hz} = {3{h}};
    r.pinned = 1'b0;
    r.want = ST_MATCH;
    return r;
  endfunction

  function automatic req_t pin(req_t r, status_e st);
    r.pinned = 1'b1;
    r.want = st;
    return r;
  endfunction

  function automatic crd_t wide_coord();
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      default: return crd_t'($urandom);
    endcase
  endfunction

  function automatic void rand_axis(output crd_t o, output crd_t l, output crd_t h);
    int   ext_lo;
    int   ext_hi;
    crd_t t;
    ext_lo = (int'($urandom_range(0, 8)) <<< 16) + int'($urandom_range(0, 16'hffff));
    ext_hi = (int'($urandom_range(0, 8)) <<< 16) + int'($urandom_range(0, 16'hffff));
    if ($urandom_range(0, 7) == 0) o = wide_coord();
    else o = crd_t'((int'($urandom_range(0, 40)) - 20) <<< 16);
    l = crd_t'(-ext_lo);
    h = crd_t'(ext_hi);
    // inverted extent
    if ($urandom_range(0, 9) == 0) begin
      t = l;
      l = h;
      h = t;
    end
    if ($urandom_range(0, 9) == 0) l = wide_coord();
    if ($urandom_range(0, 9) == 0) h = wide_coord();
  endfunction

  function automatic req_t rand_req(op_e op);
    req_t r;
    r.op = op;
    r.pinned = 1'b0;
    r.want = ST_MATCH;
    if ($urandom_range(0, 11) == 0) r.tag = TAG_W'($urandom);
    else r.tag = TAG_W'($urandom_range(0, 7));
    rand_axis(r.ox, r.lx, r.hx);
    rand_axis(r.oy, r.ly, r.hy);
    rand_axis(r.oz, r.lz, r.hz);
    // whole-space query
    if (op == OP_QUERY_BOX && $urandom_range(0, 9) == 0) begin
      {r.ox, r.oy, r.oz} = '0;
      {r.lx, r.ly, r.lz} = {3{C_MIN}};
      {r.hx, r.hy, r.hz} = {3{C_MAX}};
    end
    return r;
  endfunction

  function automatic void note_bad(string what);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t: %s, got status %0d index %0d tag %h last %b",
               $time, what, out_status, out_index, out_tag, out_last);
  endfunction

  task automatic offer(req_t r);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cur = r;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_bad("result with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.st || out_index !== want.idx ||
              out_tag !== want.tag || out_last !== want.last)
            note_bad($sformatf("mismatch, expected status %0d index %0d tag %h last %b",
                               want.st, want.idx, want.tag, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        compute_overlaps(cur);
        if (cur.pinned) begin
          void'(pending_results.pop_back());
          add_result(cur.want, 0, '0, 1'b1);
        end
      end
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : stimulus
    req_t plan [$];
    int   n_add;
    int   n_q;
    int   rnd;
    op_e  qop;
    cur = mk(OP_CLEAR, '0, '0, '0, '0);
    n_bad = 0;
    n_sent = 0;
    n_boxes = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table after reset
    plan.push_back(pin(mk(OP_QUERY_BOX, '0, '0, C_MIN, C_MAX), ST_NO_MATCH));
    plan.push_back(pin(mk(OP_QUERY_TAG, '0, '0, '0, '0), ST_NOT_IN_MAP));
    // saturating sums at both ends, whole-space, inverted and touching boxes
    plan.push_back(pin(mk(OP_ADD, 16'hffff, C_MAX, C_MAX, C_MAX), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h0000, C_MIN, C_MIN, C_MIN), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h0001, '0, C_MIN, C_MAX), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h0002, '0, C_ONE, -C_ONE), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h0003, '0, -C_ONE, C_ONE), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h0003, 2 * C_ONE, -C_ONE, '0), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h8000, -C_ONE, C_MIN, '0), ST_ADDED));
    plan.push_back(pin(mk(OP_ADD, 16'h5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555),
                       ST_ADDED));
    // stored-tag queries, duplicate tag and inverted box
    plan.push_back(mk(OP_QUERY_TAG, 16'h0003, '0, '0, '0));
    plan.push_back(mk(OP_QUERY_TAG, 16'hffff, C_MIN, C_MIN, C_MIN));
    plan.push_back(mk(OP_QUERY_TAG, 16'h0002, '0, '0, '0));
    plan.push_back(mk(OP_QUERY_TAG, 16'h0000, '0, '0, '0));
    plan.push_back(pin(mk(OP_QUERY_TAG, 16'h1234, '0, '0, '0), ST_NOT_IN_MAP));
    // box queries: boundary point, saturated query, inverted query, mixed bits
    plan.push_back(mk(OP_QUERY_BOX, 16'hffff, 2 * C_ONE, '0, '0));
    plan.push_back(mk(OP_QUERY_BOX, '0, C_MIN, C_MIN, C_MAX));
    plan.push_back(mk(OP_QUERY_BOX, '0, '0, C_ONE, -C_ONE));
    plan.push_back(mk(OP_QUERY_BOX, 16'haaaa, 32'sh5555_5555, 32'shaaaa_aaaa, '0));
    plan.push_back(mk(OP_QUERY_BOX, '0, '0, C_MIN, C_MAX));
    plan.push_back(pin(mk(OP_CLEAR, 16'hffff, C_MAX, C_MAX, C_MAX), ST_CLEARED));
    plan.push_back(pin(mk(OP_QUERY_BOX, '0, '0, C_MIN, C_MAX), ST_NO_MATCH));
    plan.push_back(pin(mk(OP_QUERY_TAG, 16'hffff, '0, '0, '0), ST_NOT_IN_MAP));
    plan.push_back(pin(mk(OP_CLEAR, '0, '0, '0, '0), ST_CLEARED));
    foreach (plan[k]) offer(plan[k]);

    rnd = 0;
    while (n_sent < N_ITEMS) begin
      no_idle = (n_sent >= CALM_AT) || (rnd % 6 == 4);
      if (rnd % 5 == 3) drain();
      if (rnd == 0 || $urandom_range(0, 3) != 0) offer(rand_req(OP_CLEAR));
      if (rnd == 0) n_add = ENTRIES + 2;
      else if ($urandom_range(0, 4) == 0) n_add = $urandom_range(ENTRIES - 4, ENTRIES + 4);
      else n_add = $urandom_range(1, 12);
      repeat (n_add) offer(rand_req(OP_ADD));
      // first round: full table and a whole-space query, output held off meanwhile
      if (rnd == 0) begin
        offer(mk(OP_QUERY_BOX, '0, '0, C_MIN, C_MAX));
        hold_req = 1'b1;
      end
      n_q = $urandom_range(3, 10);
      for (int k = 0; k < n_q; k++) begin
        case ($urandom_range(0, 15))
          0:                   qop = OP_CLEAR;
          1, 2:                qop = OP_ADD;
          3, 4, 5, 6, 7, 8, 9: qop = OP_QUERY_TAG;
          default:             qop = OP_QUERY_BOX;
        endcase
        offer(rand_req(qop));
      end
      rnd++;
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (n_bad == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
sv/aoqt_pkg.sv
sv/aoqt_sat.sv
sv/aoqt_store.sv
sv/aoqt_ctrl.sv
sv/aabb_overlap_query_table.sv
sv/aoqt_chk.sv
test/tb_top.sv
